// ----- rtl/pls_pkg.sv -----
// Package for the positional list store: list depth, derived widths,
// command and status codes. Depends on nothing.
`default_nettype none

package pls_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 6;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_INSERT     = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// Top level of the positional list store: a row of entry cells that shift by
// at most one place per command, with a two-deep result buffer.
// Depends on pls_pkg.
//
// Usage:
//   Commands arrive on the s_axis channel, one per transfer: push back, push
//   front, pop front, pop back, or insert at a position (0 is the front, a
//   position at or past the count appends at the back). Each command yields
//   exactly one result transfer on m_axis with status, count, head and tail.
//   The list update and the result are computed in the cycle a command is
//   accepted; the result is registered in the result or the skid register.
//   One command per cycle while s_axis_tready is high: every cell loads its
//   own, its left or its right neighbor's value; the cell row sets the rate.
//   A result register plus a skid register hold results while m_axis_tready
//   is low; s_axis_tready drops only once both are full, and rises again the
//   cycle after a result transfer frees one of them.
//   Reset clears the entry count and the result buffer; cell contents are
//   left as they are and are never read before being written.
//   Pops on an empty list report status 1, pushes on a full list status 2,
//   and neither changes the list. Unused command codes leave it unchanged.
`default_nettype none

module positional_list_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] cmd, [34:3] value, [40:35] position, [47:41] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [7:2] count, [39:8] head_value, [71:40] tail_value
  output logic [71:0]      m_axis_tdata
);

  typedef struct packed {
    logic signed [31:0] tail_value;
    logic signed [31:0] head_value;
    logic [5:0]         count;
    logic [1:0]         status;
  } result_t;

  logic signed [31:0] cell_q [pls_pkg::DEPTH];
  logic signed [31:0] cell_d [pls_pkg::DEPTH];
  logic [pls_pkg::CNT_W-1:0] cnt_q, cnt_d;

  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;

  logic [2:0]                 cmd;
  logic signed [31:0]         value;
  logic [pls_pkg::POS_W-1:0]  position;
  logic                       accept, take;

  logic                       is_put, is_pop_front, is_pop_back;
  logic                       full, empty;
  logic [1:0]                 res_status;
  logic [pls_pkg::CNT_W-1:0]  put_pos, ins_pos;
  logic [pls_pkg::IDX_W-1:0]  tail_sel;
  logic                       tail_from_value;
  logic signed [31:0]         tail_read;

  assign cmd      = s_axis_tdata[2:0];
  assign value    = s_axis_tdata[34:3];
  assign position = s_axis_tdata[40:35];

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign full  = (cnt_q == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign empty = (cnt_q == '0);

  // clamp insert position to the count
  assign ins_pos = (pls_pkg::CMP_W'(position) >= pls_pkg::CMP_W'(cnt_q)) ?
                   cnt_q : pls_pkg::CNT_W'(position);

  always_comb begin
    is_put       = 1'b0;
    is_pop_front = 1'b0;
    is_pop_back  = 1'b0;
    put_pos      = cnt_q;
    res_status   = pls_pkg::ST_DONE;
    case (cmd)
      pls_pkg::CMD_PUSH_BACK: begin
        is_put  = !full;
        put_pos = cnt_q;
      end
      pls_pkg::CMD_PUSH_FRONT: begin
        is_put  = !full;
        put_pos = '0;
      end
      pls_pkg::CMD_INSERT: begin
        is_put  = !full;
        put_pos = ins_pos;
      end
      pls_pkg::CMD_POP_FRONT: begin
        is_pop_front = !empty;
      end
      pls_pkg::CMD_POP_BACK: begin
        is_pop_back = !empty;
      end
      default: begin
      end
    endcase
    if ((cmd inside {pls_pkg::CMD_PUSH_BACK, pls_pkg::CMD_PUSH_FRONT,
                     pls_pkg::CMD_INSERT}) && full) begin
      res_status = pls_pkg::ST_FULL;
    end else if ((cmd inside {pls_pkg::CMD_POP_FRONT, pls_pkg::CMD_POP_BACK}) &&
                 empty) begin
      res_status = pls_pkg::ST_EMPTY;
    end
  end

  // each cell keeps, takes the new value, or takes a neighbor
  always_comb begin
    for (int i = 0; i < pls_pkg::DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (is_put) begin
        if (pls_pkg::CNT_W'(i) == put_pos) begin
          cell_d[i] = value;
        end else if (i > 0 && pls_pkg::CNT_W'(i) > put_pos) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if (is_pop_front && i < pls_pkg::DEPTH - 1) begin
        cell_d[i] = cell_q[(i < pls_pkg::DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (is_put) begin
      cnt_d = cnt_q + pls_pkg::CNT_W'(1);
    end else if (is_pop_front || is_pop_back) begin
      cnt_d = cnt_q - pls_pkg::CNT_W'(1);
    end
  end

  // tail is the new value for a put at the end, else from the old row:
  // the shift keeps the old tail last, a pop back exposes the one before it
  always_comb begin
    tail_from_value = is_put && (put_pos == cnt_q);
    if (is_pop_back) begin
      tail_sel = pls_pkg::IDX_W'(cnt_q - pls_pkg::CNT_W'(2));
    end else begin
      tail_sel = pls_pkg::IDX_W'(cnt_q - pls_pkg::CNT_W'(1));
    end
  end

  assign tail_read = cell_q[tail_sel];

  always_comb begin
    res.status = res_status;
    res.count  = 6'(cnt_d);
    if (cnt_d == '0) begin
      res.head_value = '0;
      res.tail_value = '0;
    end else begin
      if (is_put && put_pos == '0) begin
        res.head_value = value;
      end else if (is_pop_front) begin
        res.head_value = cell_q[1];
      end else begin
        res.head_value = cell_q[0];
      end
      res.tail_value = tail_from_value ? value : tail_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < pls_pkg::DEPTH; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

`default_nettype wire
